>>> rtl/ppt_pkg.sv
`default_nettype none

package ppt_pkg;

    // Register file shape: eight 64-bit registers, two matrix elements each.
    localparam int NUM_COEF_REGS = 8;
    localparam int NUM_ELEMS     = 16;
    localparam int COEF_IDX_W    = 3;
    localparam int REG_W         = 64;
    localparam int HALF_W        = 32;

    // Width of one coordinate slot on the stream ports.
    localparam int PORT_W = 32;

    // Register indexes of the coefficient pairs.
    localparam logic [COEF_IDX_W-1:0] IDX_PAIR_0 = 3'd0;
    localparam logic [COEF_IDX_W-1:0] IDX_PAIR_2 = 3'd2;
    localparam logic [COEF_IDX_W-1:0] IDX_PAIR_5 = 3'd5;
    localparam logic [COEF_IDX_W-1:0] IDX_PAIR_7 = 3'd7;

    // Status that travels with each quotient.
    typedef struct packed {
        logic w_zero;
        logic sat;
    } ppt_flags_t;

endpackage

`default_nettype wire

>>> rtl/ppt_dot.sv
`default_nettype none

module ppt_dot #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32,
    parameter int ACC_W     = 50
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [WORD_BITS-1:0] px,
    input  wire logic signed [WORD_BITS-1:0] py,
    input  wire logic signed [WORD_BITS-1:0] pz,
    input  wire logic signed [WORD_BITS-1:0] m [ppt_pkg::NUM_ELEMS],
    output logic signed [ACC_W-1:0]          num [4]
);
    import ppt_pkg::*;

    localparam int FULL_W = 2 * WORD_BITS;
    localparam int PROD_W = FULL_W - FRAC_BITS;

    logic signed [PROD_W-1:0]    prod_reg [12];
    logic signed [WORD_BITS-1:0] trn_reg  [4];
    logic signed [ACC_W-1:0]     num_reg  [4];

    // Stage one: twelve products, floored to FRAC_BITS fraction bits.
    genvar g;
    generate
        for (g = 0; g < 12; g++)
        begin : g_mul
            logic signed [FULL_W-1:0] pa;
            logic signed [FULL_W-1:0] pb;
            logic signed [FULL_W-1:0] p;
            always_comb
            begin
                pa = (g / 4 == 0) ? FULL_W'(px) : ((g / 4 == 1) ? FULL_W'(py) : FULL_W'(pz));
                pb = FULL_W'(m[g]);
                p  = pa * pb;
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    prod_reg[g] <= p[FULL_W-1:FRAC_BITS];
                end
            end
        end

        // Stage two: row sums plus the translation column.
        for (g = 0; g < 4; g++)
        begin : g_sum
            logic signed [ACC_W-1:0] num_next;
            always_comb
            begin
                num_next = ACC_W'(prod_reg[g]) + ACC_W'(prod_reg[4 + g])
                         + ACC_W'(prod_reg[8 + g])
                         + (ACC_W'(trn_reg[g]) <<< FRAC_BITS);
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    trn_reg[g] <= m[12 + g];
                    num_reg[g] <= num_next;
                end
            end
            assign num[g] = num_reg[g];
        end
    endgenerate

endmodule

`default_nettype wire

>>> rtl/ppt_div_lane.sv
`default_nettype none

module ppt_div_lane #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32,
    parameter int ACC_W     = 50
) (
    input  wire logic                        clk,
    input  wire logic                        en,
    input  wire logic signed [ACC_W-1:0]     num,
    input  wire logic signed [ACC_W-1:0]     den,
    output logic signed [WORD_BITS-1:0]      quot,
    output ppt_pkg::ppt_flags_t              flags
);
    import ppt_pkg::*;

    localparam int QW  = WORD_BITS + 1;
    localparam int NW  = ACC_W + FRAC_BITS;
    localparam int TW  = NW - QW;
    localparam int CW  = (TW > ACC_W) ? TW : ACC_W;
    localparam int NST = QW + 1;

    localparam logic [QW-1:0] MAX_POS = {2'b00, {(WORD_BITS-1){1'b1}}};
    localparam logic [QW-1:0] MAX_NEG = {2'b01, {(WORD_BITS-1){1'b0}}};

    logic [ACC_W-1:0] rem_reg  [NST];
    logic [ACC_W-1:0] d_reg    [NST];
    logic [QW-1:0]    low_reg  [NST];
    logic [QW-1:0]    q_reg    [NST];
    logic             neg_reg  [NST];
    logic             zero_reg [NST];
    logic             pre_reg  [NST];

    // Setup: magnitudes, sign, zero weight and the early overflow test.
    logic [ACC_W-1:0] n_mag;
    logic [ACC_W-1:0] d_mag;
    logic [NW-1:0]    n_ext;
    logic [CW-1:0]    top_c;
    logic [CW-1:0]    d_c;
    logic             pre;

    always_comb
    begin
        n_mag = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
        d_mag = den[ACC_W-1] ? ACC_W'(-den) : ACC_W'(den);
        n_ext = {n_mag, {FRAC_BITS{1'b0}}};
        top_c = CW'(n_ext[NW-1:QW]);
        d_c   = CW'(d_mag);
        pre   = (top_c >= d_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= pre ? '0 : top_c[ACC_W-1:0];
            d_reg[0]    <= d_mag;
            low_reg[0]  <= n_ext[QW-1:0];
            q_reg[0]    <= '0;
            neg_reg[0]  <= num[ACC_W-1] ^ den[ACC_W-1];
            zero_reg[0] <= (den == '0);
            pre_reg[0]  <= pre;
        end
    end

    // One restoring step per stage, one quotient bit each.
    genvar i;
    generate
        for (i = 0; i < QW; i++)
        begin : g_step
            logic [ACC_W:0] trial;
            logic           take;
            always_comb
            begin
                trial = {rem_reg[i], low_reg[i][QW-1]};
                take  = (trial >= {1'b0, d_reg[i]});
            end
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[i+1]  <= take ? ACC_W'(trial - {1'b0, d_reg[i]})
                                          : trial[ACC_W-1:0];
                    d_reg[i+1]    <= d_reg[i];
                    low_reg[i+1]  <= {low_reg[i][QW-2:0], 1'b0};
                    q_reg[i+1]    <= {q_reg[i][QW-2:0], take};
                    neg_reg[i+1]  <= neg_reg[i];
                    zero_reg[i+1] <= zero_reg[i];
                    pre_reg[i+1]  <= pre_reg[i];
                end
            end
        end
    endgenerate

    // Final stage: apply the sign, saturate to the word range, and force zero on a zero weight.
    logic [QW-1:0]          qf;
    logic [QW-1:0]          qneg;
    logic                   sat;
    logic [WORD_BITS-1:0]   quot_next;
    logic [WORD_BITS-1:0]   quot_reg;
    ppt_flags_t             flags_next;
    ppt_flags_t             flags_reg;

    always_comb
    begin
        qf   = q_reg[NST-1];
        qneg = '0 - qf;
        if (neg_reg[NST-1])
        begin
            sat = pre_reg[NST-1] || (qf > MAX_NEG);
        end
        else
        begin
            sat = pre_reg[NST-1] || (qf > MAX_POS);
        end

        if (zero_reg[NST-1])
        begin
            quot_next = '0;
        end
        else if (neg_reg[NST-1])
        begin
            quot_next = sat ? MAX_NEG[WORD_BITS-1:0] : qneg[WORD_BITS-1:0];
        end
        else
        begin
            quot_next = sat ? MAX_POS[WORD_BITS-1:0] : qf[WORD_BITS-1:0];
        end
        flags_next.w_zero = zero_reg[NST-1];
        flags_next.sat    = sat && !zero_reg[NST-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg  <= quot_next;
            flags_reg <= flags_next;
        end
    end

    assign quot  = signed'(quot_reg);
    assign flags = flags_reg;

endmodule

`default_nettype wire

>>> rtl/projective_point_transform.sv
`default_nettype none

// Transforms one Q(WORD_BITS-FRAC_BITS).FRAC_BITS point per clock while the
// output is not stalled, through a column-major 4x4 matrix, and divides x, y
// and z by the homogeneous w. The matrix lives in eight 64-bit registers (two
// elements each, low half first) that reset to identity; write them only while
// no point is in flight. A point passes through two stages that form the
// products and row sums, one that prepares the divide, one restoring divider
// stage per quotient bit (WORD_BITS + 1 of them, three lanes side by side) that
// produces the quotient, and a last stage that saturates it. A zero w gives zero
// outputs with w_zero set; a clipped component sets overflow. The whole
// pipeline holds when the output is stalled.
module projective_point_transform #(
    parameter int FRAC_BITS = 16,
    parameter int WORD_BITS = 32
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Configuration write port.
    input  wire logic                               cfg_we,
    input  wire logic [ppt_pkg::COEF_IDX_W-1:0]     cfg_index,
    input  wire logic [ppt_pkg::REG_W-1:0]          cfg_data,
    // Input point stream.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [3*ppt_pkg::PORT_W-1:0]       s_tdata,  // point_x, point_y, point_z
    // Result stream.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    output logic [3*ppt_pkg::PORT_W-1:0]            m_tdata,  // out_x, out_y, out_z
    output logic [1:0]                              m_tuser   // w_zero, overflow
);
    import ppt_pkg::*;

    localparam int PROD_W = 2 * WORD_BITS - FRAC_BITS;
    localparam int TRN_W  = WORD_BITS + FRAC_BITS;
    localparam int ACC_W  = ((PROD_W > TRN_W) ? PROD_W : TRN_W) + 2;
    localparam int LAT    = WORD_BITS + 5;

    localparam logic [REG_W-1:0] ONE_LO = REG_W'(1) << FRAC_BITS;
    localparam logic [REG_W-1:0] ONE_HI = REG_W'(1) << (HALF_W + FRAC_BITS);

    // Coefficient registers, identity after reset.
    logic [REG_W-1:0] coef_reg [NUM_COEF_REGS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_COEF_REGS; k++)
            begin
                if (k == int'(IDX_PAIR_0) || k == int'(IDX_PAIR_5))
                begin
                    coef_reg[k] <= ONE_LO;
                end
                else if (k == int'(IDX_PAIR_2) || k == int'(IDX_PAIR_7))
                begin
                    coef_reg[k] <= ONE_HI;
                end
                else
                begin
                    coef_reg[k] <= '0;
                end
            end
        end
        else if (cfg_we)
        begin
            coef_reg[cfg_index] <= cfg_data;
        end
    end

    // Unpack matrix elements from the register halves.
    logic signed [WORD_BITS-1:0] elem [NUM_ELEMS];

    genvar g;
    generate
        for (g = 0; g < NUM_ELEMS; g++)
        begin : g_elem
            assign elem[g] = signed'(coef_reg[g / 2][(g % 2) * HALF_W +: WORD_BITS]);
        end
    endgenerate

    // The whole pipeline advances together unless the output word is stalled.
    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    logic [LAT-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    assign m_tvalid = vld_reg[LAT-1];

    // Products and row sums.
    logic signed [ACC_W-1:0] num [4];

    ppt_dot #(
        .FRAC_BITS (FRAC_BITS),
        .WORD_BITS (WORD_BITS),
        .ACC_W     (ACC_W)
    ) u_dot (
        .clk   (clk),
        .en    (en),
        .px    (signed'(s_tdata[WORD_BITS-1:0])),
        .py    (signed'(s_tdata[PORT_W +: WORD_BITS])),
        .pz    (signed'(s_tdata[2*PORT_W +: WORD_BITS])),
        .m     (elem),
        .num   (num)
    );

    // Three divider lanes sharing the same weight.
    logic signed [WORD_BITS-1:0] quot  [3];
    ppt_flags_t                  flags [3];

    generate
        for (g = 0; g < 3; g++)
        begin : g_lane
            ppt_div_lane #(
                .FRAC_BITS (FRAC_BITS),
                .WORD_BITS (WORD_BITS),
                .ACC_W     (ACC_W)
            ) u_lane (
                .clk   (clk),
                .en    (en),
                .num   (num[g]),
                .den   (num[3]),
                .quot  (quot[g]),
                .flags (flags[g])
            );
            assign m_tdata[g*PORT_W +: PORT_W] = PORT_W'(quot[g]);
        end
    endgenerate

    assign m_tuser[0] = flags[0].w_zero;
    assign m_tuser[1] = flags[0].sat || flags[1].sat || flags[2].sat;

    // A zero weight forces zero outputs and never reports overflow.
    a_wzero_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
        else $error("w_zero result carries data or overflow");

    // All lanes agree on the zero-weight status.
    a_lanes_agree: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (flags[0].w_zero == flags[1].w_zero && flags[1].w_zero == flags[2].w_zero))
        else $error("divider lanes disagree on zero weight");

    // A stalled result word does not disappear.
    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result word lost or changed");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

module testbench;
    import ppt_pkg::*;

    localparam int FRAC    = 16;
    localparam int WDOG    = 4000;
    localparam int DRAIN   = 60;
    localparam int STALL_AT = 350;
    localparam int STALL_LEN = 250;

    // Matrix styles that the phases step through.
    typedef enum int {
        MAT_IDENTITY, MAT_AFFINE, MAT_PERSPECTIVE, MAT_RANDOM_BITS, MAT_EXTREME, MAT_ZERO_WEIGHT
    } matrix_kind_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } point_t;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        w_zero;
        logic        overflow;
    } transformed_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [COEF_IDX_W-1:0]         cfg_index;
    logic [REG_W-1:0]              cfg_data;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [3*PORT_W-1:0]           s_tdata;   // point_x, point_y, point_z
    logic                          m_tvalid;
    logic                          m_tready;
    logic [3*PORT_W-1:0]           m_tdata;   // out_x, out_y, out_z
    logic [1:0]                    m_tuser;   // w_zero, overflow

    projective_point_transform u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // Shadow copy of the coefficient registers.
    logic [REG_W-1:0] coef_shadow [NUM_COEF_REGS];

    point_t       points_pending [$];
    transformed_t transformed_due [$];

    int  errors;
    int  points_sent;
    int  words_seen;
    int  w_zero_seen;
    int  overflow_seen;
    bit  no_idling;
    int  src_gap;
    int  sink_gap;
    int  stall_left;
    bit  stall_done;
    int  quiet_cycles;

    // Clock generator.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Matrix element k as a signed value.
    function automatic logic signed [63:0] element(int k);
        logic [63:0] pair;
        logic [31:0] half;
        pair = coef_shadow[k / 2];
        half = (k % 2) ? pair[63:32] : pair[31:0];
        return {{32{half[31]}}, half};
    endfunction

    // One row of the matrix applied to the point, products floored.
    function automatic logic signed [63:0] row_sum(logic signed [63:0] x,
                                                   logic signed [63:0] y,
                                                   logic signed [63:0] z, int c);
        logic signed [63:0] acc;
        acc = ((x * element(c)) >>> FRAC) + ((y * element(4 + c)) >>> FRAC)
            + ((z * element(8 + c)) >>> FRAC) + (element(12 + c) <<< FRAC);
        return acc;
    endfunction

    // Signed num * 2^FRAC / den, truncated toward zero, saturated to 32 bits.
    function automatic logic [31:0] scaled_divide(logic signed [63:0] num,
                                                  logic signed [63:0] den,
                                                  inout logic clipped);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic         neg;
        n   = (num < 0) ? 128'(-num) : 128'(num);
        d   = (den < 0) ? 128'(-den) : 128'(den);
        neg = (num < 0) != (den < 0);
        q   = (n << FRAC) / d;
        if (!neg)
        begin
            if (q > 128'h7FFF_FFFF)
            begin
                clipped = 1'b1;
                q = 128'h7FFF_FFFF;
            end
        end
        else if (q > 128'h8000_0000)
        begin
            clipped = 1'b1;
            q = 128'h8000_0000;
        end
        return neg ? 32'(-q) : q[31:0];
    endfunction

    function automatic transformed_t transform_point(point_t p);
        transformed_t       r;
        logic signed [63:0] xs;
        logic signed [63:0] ys;
        logic signed [63:0] zs;
        logic signed [63:0] w;
        logic               clipped;
        xs = {{32{p.x[31]}}, p.x};
        ys = {{32{p.y[31]}}, p.y};
        zs = {{32{p.z[31]}}, p.z};
        w  = row_sum(xs, ys, zs, 3);
        clipped = 1'b0;
        r = '{default: '0};
        if (w == 0)
        begin
            r.w_zero = 1'b1;
        end
        else
        begin
            r.x = scaled_divide(row_sum(xs, ys, zs, 0), w, clipped);
            r.y = scaled_divide(row_sum(xs, ys, zs, 1), w, clipped);
            r.z = scaled_divide(row_sum(xs, ys, zs, 2), w, clipped);
            r.overflow = clipped;
        end
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
        errors++;
        $display("mismatch on word %0d: %s got %h expected %h", words_seen, field, got, want);
    endtask

    // Point driver: holds a word until taken, inserts idle bursts between words.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            src_gap  = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                transformed_due.push_back(transform_point('{s_tdata[31:0], s_tdata[63:32],
                                                            s_tdata[95:64]}));
                points_sent++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (points_pending.size() > 0 && !no_idling && $urandom_range(0, 7) == 0)
                begin
                    src_gap = $urandom_range(0, 4);
                    s_tvalid <= 1'b0;
                end
                else if (points_pending.size() > 0)
                begin
                    point_t p;
                    p = points_pending.pop_front();
                    s_tdata  <= {p.z, p.y, p.x};
                    s_tvalid <= 1'b1;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor and backpressure, with one long hold-off partway through.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            sink_gap   = 0;
            stall_left = 0;
            stall_done = 1'b0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (transformed_due.size() == 0)
                begin
                    errors++;
                    $display("unexpected result word %h / %b", m_tdata, m_tuser);
                end
                else
                begin
                    transformed_t want;
                    want = transformed_due.pop_front();
                    if (m_tdata[31:0] !== want.x)
                        report_mismatch("out_x", m_tdata[31:0], want.x);
                    if (m_tdata[63:32] !== want.y)
                        report_mismatch("out_y", m_tdata[63:32], want.y);
                    if (m_tdata[95:64] !== want.z)
                        report_mismatch("out_z", m_tdata[95:64], want.z);
                    if (m_tuser[0] !== want.w_zero)
                        report_mismatch("w_zero", 32'(m_tuser[0]), 32'(want.w_zero));
                    if (m_tuser[1] !== want.overflow)
                        report_mismatch("overflow", 32'(m_tuser[1]), 32'(want.overflow));
                    w_zero_seen   += want.w_zero;
                    overflow_seen += want.overflow;
                end
                words_seen++;
            end
            if (!stall_done && words_seen >= STALL_AT)
            begin
                stall_done = 1'b1;
                stall_left = STALL_LEN;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else if (!no_idling && $urandom_range(0, 6) == 0)
            begin
                sink_gap = $urandom_range(0, 4);
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WDOG)
        begin
            $display("timeout: no word moved for %0d cycles", WDOG);
            $display("projective_point_transform test failed");
            $finish;
        end
    end

    function automatic logic [31:0] small_q();
        return 32'($signed($urandom) >>> $urandom_range(8, 16));
    endfunction

    function automatic logic [31:0] coordinate();
        logic [31:0] picks [5];
        picks = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF};
        case ($urandom_range(0, 9))
            0:       return picks[$urandom_range(0, 4)];
            1, 2:    return $urandom;
            default: return 32'($signed($urandom) >>> $urandom_range(4, 20));
        endcase
    endfunction

    task automatic write_register(int idx, logic [63:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= COEF_IDX_W'(idx);
        cfg_data  <= value;
        coef_shadow[idx] = value;
    endtask

    // Loads a whole matrix of the given style; only called while idle.
    task automatic load_matrix(matrix_kind_t kind);
        logic [31:0] m [NUM_ELEMS];
        for (int k = 0; k < NUM_ELEMS; k++)
            m[k] = '0;
        case (kind)
            MAT_IDENTITY:
            begin
                m[0] = 32'h1_0000; m[5] = 32'h1_0000; m[10] = 32'h1_0000; m[15] = 32'h1_0000;
            end
            MAT_AFFINE:
            begin
                for (int k = 0; k < NUM_ELEMS; k++)
                    m[k] = small_q();
                m[3] = '0; m[7] = '0; m[11] = '0; m[15] = 32'h1_0000;
            end
            MAT_PERSPECTIVE:
            begin
                for (int k = 0; k < NUM_ELEMS; k++)
                    m[k] = small_q();
                if ($urandom_range(0, 1))
                    m[15] = '0;
            end
            MAT_RANDOM_BITS:
            begin
                for (int k = 0; k < NUM_ELEMS; k++)
                    m[k] = $urandom;
            end
            MAT_EXTREME:
            begin
                for (int k = 0; k < NUM_ELEMS; k++)
                    m[k] = ((k + $urandom_range(0, 1)) % 2) ? 32'h7FFF_FFFF : 32'h8000_0000;
            end
            MAT_ZERO_WEIGHT:
            begin
                for (int k = 0; k < NUM_ELEMS; k++)
                    m[k] = small_q();
                m[3] = '0; m[7] = '0; m[11] = '0; m[15] = '0;
            end
            default:
            begin
            end
        endcase
        for (int i = 0; i < NUM_COEF_REGS; i++)
            write_register(i, {m[2 * i + 1], m[2 * i]});
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until the queue, the driver and the block are all empty, and stay so.
    task automatic wait_idle();
        do
        begin
            while (points_pending.size() > 0 || s_tvalid || transformed_due.size() > 0)
                @(posedge clk);
            repeat (8) @(posedge clk);
        end
        while (points_pending.size() > 0 || s_tvalid || transformed_due.size() > 0);
    endtask

    // Stimulus sequence.
    initial
    begin
        matrix_kind_t kinds [6];
        kinds = '{MAT_AFFINE, MAT_PERSPECTIVE, MAT_ZERO_WEIGHT,
                  MAT_RANDOM_BITS, MAT_EXTREME, MAT_IDENTITY};
        errors = 0; points_sent = 0; words_seen = 0;
        w_zero_seen = 0; overflow_seen = 0; no_idling = 1'b0;
        quiet_cycles = 0;
        cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        rst_n = 1'b0;
        for (int i = 0; i < NUM_COEF_REGS; i++)
            coef_shadow[i] = '0;
        coef_shadow[0] = 64'h1_0000;
        coef_shadow[2] = 64'h1_0000 << 32;
        coef_shadow[5] = 64'h1_0000;
        coef_shadow[7] = 64'h1_0000 << 32;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset identity with extreme and corner coordinates.
        points_pending.push_back('{32'h0, 32'h0, 32'h0});
        points_pending.push_back('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
        points_pending.push_back('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000});
        points_pending.push_back('{32'hFFFF_FFFF, 32'h1, 32'h1_0000});
        points_pending.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_0000});
        points_pending.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_FFFF});
        wait_idle();

        // Directed: zero weight from a nonzero w row, and full-scale perspective.
        load_matrix(MAT_ZERO_WEIGHT);
        write_register(1, 64'h0001_0000 << 32);
        @(posedge clk);
        cfg_we <= 1'b0;
        points_pending.push_back('{32'h0, 32'h1234_5678, 32'h8000_0000});
        points_pending.push_back('{32'h1_0000, 32'h0, 32'h0});
        points_pending.push_back('{32'hFFFF_0000, 32'h7FFF_FFFF, 32'h0});
        wait_idle();
        load_matrix(MAT_EXTREME);
        for (int i = 0; i < 8; i++)
            points_pending.push_back('{coordinate(), coordinate(), coordinate()});
        wait_idle();

        // Random phases over a rotation of matrix styles; the last one runs without idling.
        for (int ph = 0; ph < 12; ph++)
        begin
            load_matrix(kinds[ph % 6]);
            if (ph == 11)
                no_idling = 1'b1;
            for (int i = 0; i < 77; i++)
            begin
                if ($urandom_range(0, 15) == 0)
                    points_pending.push_back('{32'h0, 32'h0, 32'h0});
                else
                    points_pending.push_back('{coordinate(), coordinate(), coordinate()});
            end
            wait_idle();
        end

        repeat (DRAIN) @(posedge clk);
        $display("%0d points sent, %0d results checked across 15 matrix settings",
                 points_sent, words_seen);
        $display("%0d results with zero weight, %0d with saturation", w_zero_seen, overflow_seen);
        if (errors == 0 && transformed_due.size() == 0)
            $display("projective_point_transform test passed");
        else
            $display("projective_point_transform test failed");
        $finish;
    end

endmodule

`default_nettype wire
